### rtl/mckw_pkg.sv
// ----------------------------------------------------------------------------
// mckw_pkg
// Shared types and constants for the multi-channel kick watchdog.
// ----------------------------------------------------------------------------
package mckw_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int TIME_W = 32;
	localparam int CH_W = 3;
	localparam int CMD_W = 2;
	localparam int MASK_W = 8;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_KICK = 2'd1,
		CMD_RUN  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_OK    = 2'd1,
		MODE_ERROR = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_REPORT,
		ST_RESP
	} seq_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		mode_t             mode;
		logic              alive;
		logic              alive_upd;
	} eval_t;

endpackage

### rtl/mckw_chan_eval.sv
// ----------------------------------------------------------------------------
// mckw_chan_eval
// Elapsed time and mode update for one channel during an evaluation pass.
// ----------------------------------------------------------------------------
module mckw_chan_eval (
	input  logic [mckw_pkg::TIME_W-1:0] stamp,
	input  logic                        stamp_vld,
	input  logic [mckw_pkg::TIME_W-1:0] now_ms,
	input  logic [mckw_pkg::TIME_W-1:0] timeout_ms,
	input  mckw_pkg::mode_t             mode_cur,
	output mckw_pkg::eval_t             res
);
	import mckw_pkg::*;

	logic [TIME_W-1:0] stamp_eff;
	logic [TIME_W-1:0] elapsed;
	logic              late;

	assign stamp_eff = stamp_vld ? stamp : '0;
	assign elapsed = (stamp_eff > now_ms) ? '0 : now_ms - stamp_eff;
	assign late = (elapsed >= timeout_ms);

	always_comb begin
		res.elapsed = elapsed;
		res.mode = mode_cur;
		res.alive = 1'b1;
		res.alive_upd = 1'b0;
		unique case (mode_cur)
			MODE_INIT: begin
				res.mode = MODE_OK;
				res.alive = 1'b1;
				res.alive_upd = 1'b1;
			end
			MODE_OK: begin
				if (late) begin
					res.mode = MODE_ERROR;
					res.alive = 1'b0;
					res.alive_upd = 1'b1;
				end
			end
			MODE_ERROR: begin
				if (!late) begin
					res.mode = MODE_OK;
					res.alive = 1'b1;
					res.alive_upd = 1'b1;
				end
			end
			default: begin
				res.mode = mode_cur;
				res.alive_upd = 1'b0;
			end
		endcase
	end

endmodule

### rtl/multi_channel_kick_watchdog.sv
// Sequence: a tick or kick transaction passes the REPORT state and waits in RESP
// until the output register is free; a run transaction first passes RUN and DRAIN.
// A new transaction is accepted only in the idle state, once the last is through;
// the run pass reads one kick stamp from memory per cycle.
// Reset: asynchronous; counter 0, timeout 1000, all channels alive in init mode.
// ----------------------------------------------------------------------------
// multi_channel_kick_watchdog
// Watchdog with a millisecond counter, per-channel kick stamps and a
// sequenced evaluation pass over stamp and elapsed-time memories.
// ----------------------------------------------------------------------------
module multi_channel_kick_watchdog #(
	parameter int CHANNELS = mckw_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          timeout_we,
	input  logic [mckw_pkg::TIME_W-1:0]   timeout_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mckw_pkg::CMD_W-1:0]    cmd,
	input  logic [mckw_pkg::CH_W-1:0]     channel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mckw_pkg::MASK_W-1:0]   alive_mask,
	output logic                          all_alive,
	output logic                          channel_alive,
	output logic [mckw_pkg::TIME_W-1:0]   channel_elapsed
);
	import mckw_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

	seq_state_t state_q, state_d;

	logic [TIME_W-1:0] timeout_q;
	logic [TIME_W-1:0] now_q;
	logic [CH_W-1:0]   ch_q;
	logic [IDX_W-1:0]  cnt_q;

	logic [TIME_W-1:0] kick_mem [CHANNELS];
	logic [TIME_W-1:0] el_mem [CHANNELS];
	logic [CHANNELS-1:0] kick_valid_q;
	logic [CHANNELS-1:0] el_valid_q;
	mode_t mode_q [CHANNELS];
	logic [CHANNELS-1:0] alive_q;

	logic              proc_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TIME_W-1:0] stamp_s1;
	logic              stamp_vld_s1;

	logic [TIME_W-1:0] el_rd_q;
	logic              el_rvld_q;

	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic              all_q;
	logic              ch_alive_q;
	logic [TIME_W-1:0] ch_el_q;

	logic              accept;
	logic              out_free;
	logic              run_en;
	logic              rep_en;
	logic              load_out;
	logic [IDX_W-1:0]  in_idx;
	logic              in_range;
	logic [IDX_W-1:0]  q_idx;
	logic              q_range;
	logic [MASK_W-1:0] mask_now;
	eval_t             ev;

	assign in_idx = IDX_W'(channel);
	assign in_range = (32'(channel) < 32'(CHANNELS));
	assign q_idx = IDX_W'(ch_q);
	assign q_range = (32'(ch_q) < 32'(CHANNELS));
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cmd_t'(cmd) == CMD_RUN) ? ST_RUN : ST_REPORT;
				end
			end
			ST_RUN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_REPORT;
			ST_REPORT: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		run_en = (state_q == ST_RUN);
		rep_en = (state_q == ST_REPORT);
		load_out = (state_q == ST_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			cnt_q <= '0;
			proc_vld_s1 <= 1'b0;
		end else begin
			if (accept && cmd_t'(cmd) == CMD_TICK) begin
				now_q <= now_q + 1'b1;
			end
			if (run_en) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end
			proc_vld_s1 <= run_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= channel;
		end
		idx_s1 <= cnt_q;
	end

	// Kick stamp memory: written by kick transactions, read by the pass.
	always_ff @(posedge clk) begin
		if (accept && cmd_t'(cmd) == CMD_KICK && in_range) begin
			kick_mem[in_idx] <= now_q;
		end
		if (run_en) begin
			stamp_s1 <= kick_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_valid_q <= '0;
			stamp_vld_s1 <= 1'b0;
		end else begin
			if (accept && cmd_t'(cmd) == CMD_KICK && in_range) begin
				kick_valid_q[in_idx] <= 1'b1;
			end
			if (run_en) begin
				stamp_vld_s1 <= kick_valid_q[cnt_q];
			end
		end
	end

	mckw_chan_eval u_eval (
		.stamp      (stamp_s1),
		.stamp_vld  (stamp_vld_s1),
		.now_ms     (now_q),
		.timeout_ms (timeout_q),
		.mode_cur   (mode_q[idx_s1]),
		.res        (ev)
	);

	// Elapsed time memory: written by the pass, read for the report.
	always_ff @(posedge clk) begin
		if (proc_vld_s1) begin
			el_mem[idx_s1] <= ev.elapsed;
		end
		if (rep_en) begin
			el_rd_q <= el_mem[q_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_valid_q <= '0;
			el_rvld_q <= 1'b0;
			alive_q <= '1;
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i] <= MODE_INIT;
			end
		end else begin
			if (proc_vld_s1) begin
				el_valid_q[idx_s1] <= 1'b1;
				mode_q[idx_s1] <= ev.mode;
				if (ev.alive_upd) begin
					alive_q[idx_s1] <= ev.alive;
				end
			end
			if (rep_en) begin
				el_rvld_q <= el_valid_q[q_idx] && q_range;
			end
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_on
			assign mask_now[g] = alive_q[g];
		end else begin : g_off
			assign mask_now[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mask_q <= mask_now;
			all_q <= &alive_q;
			ch_alive_q <= q_range && alive_q[q_idx];
			ch_el_q <= el_rvld_q ? el_rd_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign alive_mask = mask_q;
	assign all_alive = all_q;
	assign channel_alive = ch_alive_q;
	assign channel_elapsed = ch_el_q;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-channel kick watchdog. Tick, kick, run
// and unused commands are driven through the input handshake under several
// timeout settings and idle patterns. A local copy of the counter, kick
// stamps and channel state machines predicts every status transaction, and
// each transaction on the output side is checked field by field.
// ----------------------------------------------------------------------------
module tb;
	import mckw_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETTLE = CHANNELS_DEF + 4;
	localparam int RANDOM_ITEMS = 1760;
	localparam int PHASES = 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic              all;
		logic              ch_alive;
		logic [TIME_W-1:0] ch_elapsed;
	} status_t;

	class watchdog_checker;
		logic [TIME_W-1:0] timeout_ms;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] kick_stamp [CHANNELS_DEF];
		mode_t             chan_mode [CHANNELS_DEF];
		logic [TIME_W-1:0] chan_elapsed [CHANNELS_DEF];
		logic              chan_alive [CHANNELS_DEF];
		status_t           pending_status [$];
		int                errors;

		function new();
			timeout_ms = TIMEOUT_RST;
			now_ms = '0;
			errors = 0;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				kick_stamp[c] = '0;
				chan_mode[c] = MODE_INIT;
				chan_elapsed[c] = '0;
				chan_alive[c] = 1'b1;
			end
		endfunction

		function void accept_command(logic [CMD_W-1:0] op, logic [CH_W-1:0] ch);
			logic [TIME_W-1:0] el;
			status_t s;
			case (op)
				CMD_TICK: begin
					now_ms = now_ms + 1'b1;
				end
				CMD_KICK: begin
					kick_stamp[ch] = now_ms;
				end
				CMD_RUN: begin
					for (int c = 0; c < CHANNELS_DEF; c++) begin
						el = (kick_stamp[c] > now_ms) ? '0 : now_ms - kick_stamp[c];
						chan_elapsed[c] = el;
						case (chan_mode[c])
							MODE_INIT: begin
								chan_mode[c] = MODE_OK;
								chan_alive[c] = 1'b1;
							end
							MODE_OK: begin
								if (el >= timeout_ms) begin
									chan_mode[c] = MODE_ERROR;
									chan_alive[c] = 1'b0;
								end
							end
							MODE_ERROR: begin
								if (el < timeout_ms) begin
									chan_mode[c] = MODE_OK;
									chan_alive[c] = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
			s.mask = '0;
			s.all = 1'b1;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				if (chan_alive[c]) begin
					if (c < MASK_W)
						s.mask[c] = 1'b1;
				end else begin
					s.all = 1'b0;
				end
			end
			s.ch_alive = chan_alive[ch];
			s.ch_elapsed = chan_elapsed[ch];
			pending_status.push_back(s);
		endfunction

		function void check_status(logic [MASK_W-1:0] mask, logic all, logic ch_alive,
				logic [TIME_W-1:0] ch_elapsed);
			status_t s;
			if (pending_status.size() == 0) begin
				$display("%0t: status transaction with none expected, mask %h", $time, mask);
				errors++;
				return;
			end
			s = pending_status.pop_front();
			if (mask !== s.mask) begin
				$display("%0t: alive_mask expected %h actual %h", $time, s.mask, mask);
				errors++;
			end
			if (all !== s.all) begin
				$display("%0t: all_alive expected %b actual %b", $time, s.all, all);
				errors++;
			end
			if (ch_alive !== s.ch_alive) begin
				$display("%0t: channel_alive expected %b actual %b", $time, s.ch_alive,
					ch_alive);
				errors++;
			end
			if (ch_elapsed !== s.ch_elapsed) begin
				$display("%0t: channel_elapsed expected %0d actual %0d", $time,
					s.ch_elapsed, ch_elapsed);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              timeout_we = 1'b0;
	logic [TIME_W-1:0] timeout_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd = CMD_TICK;
	logic [CH_W-1:0]   channel = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [MASK_W-1:0] alive_mask;
	logic              all_alive;
	logic              channel_alive;
	logic [TIME_W-1:0] channel_elapsed;

	int          idle_pct = 0;
	int          stall_pct = 0;
	int unsigned cycle_count = 0;
	watchdog_checker chk = new();

	multi_channel_kick_watchdog #(
		.CHANNELS(CHANNELS_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.timeout_we(timeout_we),
		.timeout_wdata(timeout_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.channel(channel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alive_mask(alive_mask),
		.all_alive(all_alive),
		.channel_alive(channel_alive),
		.channel_elapsed(channel_elapsed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				chk.accept_command(cmd, channel);
			if (out_valid && out_ready)
				chk.check_status(alive_mask, all_alive, channel_alive, channel_elapsed);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task send_cmd(input logic [CMD_W-1:0] op, input logic [CH_W-1:0] ch);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		channel <= ch;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task write_timeout(input logic [TIME_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		timeout_we <= 1'b1;
		timeout_wdata <= value;
		@(posedge clk);
		timeout_we <= 1'b0;
		chk.timeout_ms = value;
	endtask

	initial begin
		logic [TIME_W-1:0] phase_timeout [PHASES];
		logic [CMD_W-1:0]  op;
		logic [CH_W-1:0]   ch;
		int                pick;

		phase_timeout = '{32'd1, 32'd4, 32'd9, 32'd25, 32'd3, 32'hFFFF_FFFF, 32'd6, 32'd2};
		phase_timeout[6] = $urandom_range(12, 2);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_RUN, 3'd0);
		send_cmd(CMD_UNUSED, 3'd7);
		send_cmd(CMD_TICK, 3'd5);
		send_cmd(CMD_KICK, 3'd2);
		write_timeout(32'd2);
		send_cmd(CMD_TICK, 3'd1);
		send_cmd(CMD_TICK, 3'd3);
		send_cmd(CMD_RUN, 3'd2);
		send_cmd(CMD_KICK, 3'd7);
		send_cmd(CMD_KICK, 3'd0);
		send_cmd(CMD_RUN, 3'd7);
		send_cmd(CMD_UNUSED, 3'd4);
		send_cmd(CMD_RUN, 3'd6);
		write_timeout(32'd0);
		send_cmd(CMD_RUN, 3'd6);
		send_cmd(CMD_RUN, 3'd0);
		write_timeout(32'hFFFF_FFFF);
		send_cmd(CMD_RUN, 3'd5);
		send_cmd(CMD_TICK, 3'd7);
		send_cmd(CMD_KICK, 3'd5);
		send_cmd(CMD_RUN, 3'd3);

		for (int p = 0; p < PHASES; p++) begin
			write_timeout(phase_timeout[p]);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 57;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 57;
				end
				default: begin
					idle_pct = 32;
					stall_pct = 32;
				end
			endcase
			repeat (RANDOM_ITEMS / PHASES) begin
				pick = $urandom_range(99);
				ch = CH_W'($urandom_range(CHANNELS_DEF - 1));
				if (pick < 40)
					op = CMD_TICK;
				else if (pick < 65)
					op = CMD_KICK;
				else if (pick < 94)
					op = CMD_RUN;
				else
					op = CMD_UNUSED;
				send_cmd(op, ch);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (chk.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

### multi_channel_kick_watchdog.f
rtl/mckw_pkg.sv
rtl/mckw_chan_eval.sv
rtl/multi_channel_kick_watchdog.sv
sim/tb.sv
